[hdl/uv_sphere_vertex_triangle_gen_core_assert.svh]
`ifndef UV_SPHERE_VERTEX_TRIANGLE_GEN_CORE_ASSERT_SVH
`define UV_SPHERE_VERTEX_TRIANGLE_GEN_CORE_ASSERT_SVH

// plain check, sampled on clk_i, off during reset
`define UVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication check, sampled on clk_i, off during reset
`define UVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/uvs_pkg.sv]
package uvs_pkg;

  localparam int STACK_BITS_DEF   = 8;
  localparam int SLICE_BITS_DEF   = 8;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int IDX_W   = 8;
  localparam int UV_W    = 17;
  localparam int CRN_W   = 17;
  localparam int POS_W   = 17;
  localparam int Q30_W   = 33;
  localparam int PROD_W  = 66;
  localparam int RND_W   = 36;
  localparam int DIV_STEPS = UV_W;

  localparam logic [32:0] TURN_Q30 = 33'd6746518852;

  typedef logic signed [Q30_W-1:0] q30_t;

  localparam q30_t CORDIC_GAIN = 33'sd652032875;

  localparam q30_t ATAN_Q30 [24] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
    33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
    33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
    33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
    33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
    33'sd1023,      33'sd511,       33'sd255,       33'sd127
  };

  typedef enum logic [1:0] {
    REG_STACKS = 2'd0,
    REG_SLICES = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_VERTEX   = 1'b0,
    CMD_TRIANGLE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic             ok;
    logic [CRN_W-1:0] crn_a;
    logic [CRN_W-1:0] crn_b;
    logic [CRN_W-1:0] crn_c;
    logic [UV_W-1:0]  tex_u;
    logic [UV_W-1:0]  tex_v;
  } side_t;

  // floor((p + 2^29) / 2^30)
  function automatic logic signed [RND_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + 66'sd536870912;
    return RND_W'(t >>> 30);
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RND_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 36'sd65535) begin
      r = 17'sd65535;
    end else if (v < -36'sd65535) begin
      r = -17'sd65535;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/uvs_div.sv]
module uvs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  uvs_pkg::side_t     side_i,
  input  logic [7:0]         st_i,
  input  logic [7:0]         sl_i,
  input  logic [7:0]         stacks_i,
  input  logic [7:0]         slices_i,
  output logic               vld_o,
  output uvs_pkg::side_t     side_o
);

  localparam int N = uvs_pkg::DIV_STEPS;

  logic [7:0]              num [2];
  logic [7:0]              den [2];
  logic [7:0]              rem_q [2][N];
  logic [uvs_pkg::UV_W-1:0] quo_q [2][N];
  logic                    vld_q [N];
  uvs_pkg::side_t          side_q [N];

  assign num[0] = sl_i;
  assign den[0] = slices_i;
  assign num[1] = st_i;
  assign den[1] = stacks_i;

  // one quotient bit per stage, MSB first; lane 0 gives u, lane 1 gives v
  for (genvar k = 0; k < N; k++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [7:0]               prev;
      logic                     nbit;
      logic [8:0]               t;
      logic [8:0]               diff;
      logic                     ge;
      logic [uvs_pkg::UV_W-1:0] qprev;

      if (k == 0) begin : g_first
        assign prev  = {1'b0, num[l][7:1]};
        assign nbit  = num[l][0];
        assign qprev = '0;
      end else begin : g_next
        assign prev  = rem_q[l][k-1];
        assign nbit  = 1'b0;
        assign qprev = quo_q[l][k-1];
      end

      assign t    = {prev, nbit};
      assign ge   = t >= {1'b0, den[l]};
      assign diff = t - {1'b0, den[l]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[l][k] <= ge ? diff[7:0] : t[7:0];
          quo_q[l][k] <= qprev | (uvs_pkg::UV_W'(ge) << (N - 1 - k));
        end
      end
    end

    if (k == 0) begin : g_side0
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= vld_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          side_q[k] <= side_i;
        end
      end
    end else begin : g_siden
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  always_comb begin
    side_o       = side_q[N-1];
    side_o.tex_u = quo_q[0][N-1];
    side_o.tex_v = quo_q[1][N-1];
  end

  assign vld_o = vld_q[N-1];

endmodule

[hdl/uvs_cordic.sv]
module uvs_cordic #(
  parameter int CORDIC_STEPS = uvs_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  uvs_pkg::side_t side_i,
  output logic           vld_o,
  output uvs_pkg::side_t side_o,
  output uvs_pkg::q30_t  ct_o,
  output uvs_pkg::q30_t  sth_o,
  output uvs_pkg::q30_t  cp_o,
  output uvs_pkg::q30_t  sp_o
);

  localparam int S = CORDIC_STEPS;
  localparam int D = S + 2;

  uvs_pkg::q30_t x_q [2][S+1];
  uvs_pkg::q30_t y_q [2][S+1];
  uvs_pkg::q30_t z_q [2][S+1];
  logic [1:0]    qd_q [2][S+1];
  uvs_pkg::q30_t c_q [2];
  uvs_pkg::q30_t s_q [2];
  logic          vld_q [D];
  uvs_pkg::side_t side_q [D];
  logic [uvs_pkg::UV_W-1:0] ang [2];

  // theta = v, phi = 2u, both in 2^-17 turn
  assign ang[0] = side_i.tex_v;
  assign ang[1] = {side_i.tex_u[uvs_pkg::UV_W-2:0], 1'b0};

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [47:0] zp;
    assign zp = 48'(ang[l][14:0]) * 48'(uvs_pkg::TURN_Q30) + 48'd65536;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[l][0]  <= uvs_pkg::CORDIC_GAIN;
        y_q[l][0]  <= '0;
        z_q[l][0]  <= $signed({2'b00, zp[47:17]});
        qd_q[l][0] <= ang[l][16:15];
      end
    end

    for (genvar i = 0; i < S; i++) begin : g_step
      uvs_pkg::q30_t dx;
      uvs_pkg::q30_t dy;
      assign dx = y_q[l][i] >>> i;
      assign dy = x_q[l][i] >>> i;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          qd_q[l][i+1] <= qd_q[l][i];
          if (!z_q[l][i][uvs_pkg::Q30_W-1]) begin
            x_q[l][i+1] <= x_q[l][i] - dx;
            y_q[l][i+1] <= y_q[l][i] + dy;
            z_q[l][i+1] <= z_q[l][i] - uvs_pkg::ATAN_Q30[i];
          end else begin
            x_q[l][i+1] <= x_q[l][i] + dx;
            y_q[l][i+1] <= y_q[l][i] - dy;
            z_q[l][i+1] <= z_q[l][i] + uvs_pkg::ATAN_Q30[i];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        unique case (qd_q[l][S])
          2'd0: begin c_q[l] <= x_q[l][S];  s_q[l] <= y_q[l][S];  end
          2'd1: begin c_q[l] <= -y_q[l][S]; s_q[l] <= x_q[l][S];  end
          2'd2: begin c_q[l] <= -x_q[l][S]; s_q[l] <= -y_q[l][S]; end
          default: begin c_q[l] <= y_q[l][S]; s_q[l] <= -x_q[l][S]; end
        endcase
      end
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_pipe
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= vld_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          side_q[k] <= side_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  assign vld_o  = vld_q[D-1];
  assign side_o = side_q[D-1];
  assign ct_o   = c_q[0];
  assign sth_o  = s_q[0];
  assign cp_o   = c_q[1];
  assign sp_o   = s_q[1];

endmodule

[hdl/uvs_scale.sv]
module uvs_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  uvs_pkg::side_t                      side_i,
  input  logic [15:0]                         radius_i,
  input  uvs_pkg::q30_t                       ct_i,
  input  uvs_pkg::q30_t                       sth_i,
  input  uvs_pkg::q30_t                       cp_i,
  input  uvs_pkg::q30_t                       sp_i,
  output logic                                vld_o,
  output uvs_pkg::side_t                      side_o,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_y_o,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_z_o
);

  logic signed [16:0]                    rad;
  logic signed [uvs_pkg::PROD_W-1:0]     px_d, py_d, pz_d, mx_d, my_d;
  logic signed [uvs_pkg::PROD_W-1:0]     px_q, py_q, pz_q, mx_q, my_q;
  uvs_pkg::q30_t                         sx, sy;
  logic signed [uvs_pkg::POS_W-1:0]      posz_q;
  logic                                  vld1_q, vld2_q;
  uvs_pkg::side_t                        side1_q, side2_q;

  assign rad  = $signed({1'b0, radius_i});
  assign px_d = sth_i * cp_i;
  assign py_d = sth_i * sp_i;
  assign pz_d = rad * ct_i;
  assign sx   = uvs_pkg::Q30_W'(uvs_pkg::rnd_q30(px_q));
  assign sy   = uvs_pkg::Q30_W'(uvs_pkg::rnd_q30(py_q));
  assign mx_d = rad * sx;
  assign my_d = rad * sy;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q    <= px_d;
      py_q    <= py_d;
      pz_q    <= pz_d;
      side1_q <= side_i;
      mx_q    <= mx_d;
      my_q    <= my_d;
      posz_q  <= uvs_pkg::sat_pos(uvs_pkg::rnd_q30(pz_q));
      side2_q <= side1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  assign pos_x_o = uvs_pkg::sat_pos(uvs_pkg::rnd_q30(mx_q));
  assign pos_y_o = uvs_pkg::sat_pos(uvs_pkg::rnd_q30(my_q));
  assign pos_z_o = posz_q;
  assign vld_o   = vld2_q;
  assign side_o  = side2_q;

endmodule

[hdl/uv_sphere_vertex_triangle_gen_core.sv]
// channel  | handshake               | beat
// in       | in_valid_i / in_ready_o | command, stack_index, slice_index, second_triangle
// out      | out_valid_o/out_ready_i | valid_res, pos_x/y/z, tex_u/v, corner_a/b/c
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i (register), cfg_data_i
//
// One beat per cycle in and out while the pipe is not stalled; path: input register,
// 17 divider stages, CORDIC_STEPS + 2 rotator stages, 2 multiplier stages, output register.
// One enable moves the whole pipe; it stops only when the output register is full and
// not taken. Reset clears valid bits and loads 16 stacks, 16 slices, radius 256.
`include "uv_sphere_vertex_triangle_gen_core_assert.svh"

module uv_sphere_vertex_triangle_gen_core #(
  parameter int STACK_BITS   = uvs_pkg::STACK_BITS_DEF,
  parameter int SLICE_BITS   = uvs_pkg::SLICE_BITS_DEF,
  parameter int CORDIC_STEPS = uvs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [uvs_pkg::IDX_W-1:0]         stack_index_i,
  input  logic [uvs_pkg::IDX_W-1:0]         slice_index_i,
  input  logic                              second_triangle_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              valid_res_o,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_x_o,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_y_o,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_z_o,
  output logic [uvs_pkg::UV_W-1:0]          tex_u_o,
  output logic [uvs_pkg::UV_W-1:0]          tex_v_o,
  output logic [uvs_pkg::CRN_W-1:0]         corner_a_o,
  output logic [uvs_pkg::CRN_W-1:0]         corner_b_o,
  output logic [uvs_pkg::CRN_W-1:0]         corner_c_o
);

  localparam logic [7:0] SMASK = 8'((1 << STACK_BITS) - 1);
  localparam logic [7:0] TMASK = 8'((1 << SLICE_BITS) - 1);

  logic [7:0]  stacks_q, slices_q;
  logic [15:0] radius_q;

  logic        en;
  logic [7:0]  stacks, slices, st, sl;
  logic        deg, cap_top, cap_bot, tri_ok, vtx_ok, second;
  logic [8:0]  w;
  logic [uvs_pkg::CRN_W-1:0] top, bot;
  uvs_pkg::side_t side_d;

  logic           s0_vld_q;
  uvs_pkg::side_t s0_side_q;
  logic [7:0]     s0_st_q, s0_sl_q;

  logic           dv_vld, cr_vld, sc_vld;
  uvs_pkg::side_t dv_side, cr_side, sc_side;
  uvs_pkg::q30_t  ct, sth, cp, sp;
  logic signed [uvs_pkg::POS_W-1:0] px, py, pz;

  logic                             out_vld_q, res_q;
  logic signed [uvs_pkg::POS_W-1:0] px_q, py_q, pz_q;
  logic [uvs_pkg::UV_W-1:0]         tu_q, tv_q;
  logic [uvs_pkg::CRN_W-1:0]        ca_q, cb_q, cc_q;
  logic                             is_vtx, is_tri;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stacks_q <= 8'd16;
      slices_q <= 8'd16;
      radius_q <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        uvs_pkg::REG_STACKS: stacks_q <= cfg_data_i[7:0];
        uvs_pkg::REG_SLICES: slices_q <= cfg_data_i[7:0];
        uvs_pkg::REG_RADIUS: radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    stacks  = stacks_q & SMASK;
    slices  = slices_q & TMASK;
    st      = stack_index_i & SMASK;
    sl      = slice_index_i & TMASK;
    second  = second_triangle_i;
    deg     = (stacks < 8'd2) || (slices == 8'd0);
    cap_top = st == 8'd0;
    cap_bot = st == (stacks - 8'd1);
    w       = {1'b0, slices} + 9'd1;
    top     = uvs_pkg::CRN_W'(st * w) + uvs_pkg::CRN_W'(sl);
    bot     = top + uvs_pkg::CRN_W'(w);
    vtx_ok  = !deg && (st <= stacks) && (sl <= slices);
    tri_ok  = !deg && (st < stacks) && (sl < slices) && !(second && (cap_top || cap_bot));

    side_d       = '0;
    side_d.cmd   = uvs_pkg::cmd_e'(command_i);
    side_d.ok    = (side_d.cmd == uvs_pkg::CMD_TRIANGLE) ? tri_ok : vtx_ok;
    side_d.crn_a = top;
    if (second) begin
      side_d.crn_b = bot + 17'd1;
      side_d.crn_c = top + 17'd1;
    end else if (cap_bot && !cap_top) begin
      side_d.crn_b = bot;
      side_d.crn_c = top + 17'd1;
    end else begin
      side_d.crn_b = bot;
      side_d.crn_c = bot + 17'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_side_q <= side_d;
      s0_st_q   <= st;
      s0_sl_q   <= sl;
    end
  end

  uvs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s0_vld_q),
    .side_i   (s0_side_q),
    .st_i     (s0_st_q),
    .sl_i     (s0_sl_q),
    .stacks_i (stacks),
    .slices_i (slices),
    .vld_o    (dv_vld),
    .side_o   (dv_side)
  );

  uvs_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld),
    .side_i (dv_side),
    .vld_o  (cr_vld),
    .side_o (cr_side),
    .ct_o   (ct),
    .sth_o  (sth),
    .cp_o   (cp),
    .sp_o   (sp)
  );

  uvs_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (cr_vld),
    .side_i   (cr_side),
    .radius_i (radius_q),
    .ct_i     (ct),
    .sth_i    (sth),
    .cp_i     (cp),
    .sp_i     (sp),
    .vld_o    (sc_vld),
    .side_o   (sc_side),
    .pos_x_o  (px),
    .pos_y_o  (py),
    .pos_z_o  (pz)
  );

  assign is_vtx = sc_side.ok && (sc_side.cmd == uvs_pkg::CMD_VERTEX);
  assign is_tri = sc_side.ok && (sc_side.cmd == uvs_pkg::CMD_TRIANGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sc_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= sc_side.ok;
      px_q  <= is_vtx ? px : '0;
      py_q  <= is_vtx ? py : '0;
      pz_q  <= is_vtx ? pz : '0;
      tu_q  <= is_vtx ? sc_side.tex_u : '0;
      tv_q  <= is_vtx ? sc_side.tex_v : '0;
      ca_q  <= is_tri ? sc_side.crn_a : '0;
      cb_q  <= is_tri ? sc_side.crn_b : '0;
      cc_q  <= is_tri ? sc_side.crn_c : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign valid_res_o = res_q;
  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign pos_z_o     = pz_q;
  assign tex_u_o     = tu_q;
  assign tex_v_o     = tv_q;
  assign corner_a_o  = ca_q;
  assign corner_b_o  = cb_q;
  assign corner_c_o  = cc_q;

  `UVS_ASSERT_IMP(a_invalid_zero, out_valid_o && !valid_res_o, pos_x_o == 0 && pos_y_o == 0 && pos_z_o == 0 && tex_u_o == 0 && tex_v_o == 0 && corner_a_o == 0 && corner_b_o == 0 && corner_c_o == 0, "invalid result has nonzero fields")
  `UVS_ASSERT_IMP(a_tri_no_pos, out_valid_o && corner_b_o != 0, pos_x_o == 0 && pos_y_o == 0 && pos_z_o == 0 && tex_u_o == 0 && tex_v_o == 0, "triangle result carries vertex fields")
  `UVS_ASSERT_IMP(a_tex_range, out_valid_o, tex_u_o <= 17'd65536 && tex_v_o <= 17'd65536, "texture coordinate above one")
  `UVS_ASSERT_IMP(a_pos_sat, out_valid_o, pos_x_o != -17'sd65536 && pos_y_o != -17'sd65536 && pos_z_o != -17'sd65536, "position outside saturation range")
  `UVS_ASSERT(a_ready_flow, in_ready_o == (!out_valid_o || out_ready_i) && cfg_ready_o, "pipe enable out of step with output register")

endmodule

[tb/sv/uv_sphere_vertex_triangle_gen_core_checker.sv]
`timescale 1ns / 1ps

module uv_sphere_vertex_triangle_gen_core_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [uvs_pkg::IDX_W-1:0]         stack_index_i,
  input  logic [uvs_pkg::IDX_W-1:0]         slice_index_i,
  input  logic                              second_triangle_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic                              valid_res_o,
  input  logic signed [uvs_pkg::POS_W-1:0]  pos_x_o,
  input  logic signed [uvs_pkg::POS_W-1:0]  pos_y_o,
  input  logic signed [uvs_pkg::POS_W-1:0]  pos_z_o,
  input  logic [uvs_pkg::UV_W-1:0]          tex_u_o,
  input  logic [uvs_pkg::UV_W-1:0]          tex_v_o,
  input  logic [uvs_pkg::CRN_W-1:0]         corner_a_o,
  input  logic [uvs_pkg::CRN_W-1:0]         corner_b_o,
  input  logic [uvs_pkg::CRN_W-1:0]         corner_c_o,
  output int                                fail_count,
  output int                                pending,
  output int                                beats_out
);

  localparam int STEPS = uvs_pkg::CORDIC_STEPS_DEF;
  localparam longint POS_LIM = 65535;

  typedef struct {
    logic        ok;
    logic [16:0] px, py, pz, u, v, ca, cb, cc;
  } sphere_res_t;

  sphere_res_t expected_q[$];
  logic [7:0]  cur_stacks, cur_slices;
  logic [15:0] cur_radius;

  function automatic longint round_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp_pos(input longint p);
    if (p > POS_LIM) return POS_LIM;
    if (p < -POS_LIM) return -POS_LIM;
    return p;
  endfunction

  function automatic void rotate_angle(input int unsigned a17, output longint c,
                                       output longint s);
    longint x, y, z, dx, dy, rem;
    int unsigned q;
    q   = (a17 >> 15) & 3;
    rem = a17 & 32'h7FFF;
    z   = (rem * longint'(uvs_pkg::TURN_Q30) + 65536) >>> 17;
    x   = longint'(uvs_pkg::CORDIC_GAIN);
    y   = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(uvs_pkg::ATAN_Q30[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(uvs_pkg::ATAN_Q30[i]);
      end
    end
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic sphere_res_t predict_mesh(input uvs_pkg::cmd_e cmd, input longint st,
                                               input longint sl, input logic sec);
    sphere_res_t r;
    longint stacks, slices, u, v, ct, sth, cp, sp, w, top, bot;
    logic cap_top, cap_bot;
    r = '{default: '0};
    stacks = cur_stacks;
    slices = cur_slices;
    if (stacks < 2 || slices == 0) return r;
    if (cmd == uvs_pkg::CMD_VERTEX) begin
      if (st > stacks || sl > slices) return r;
      u = (sl << 16) / slices;
      v = (st << 16) / stacks;
      rotate_angle(int'(v & 17'h1FFFF), ct, sth);
      rotate_angle(int'((u << 1) & 17'h1FFFF), cp, sp);
      r.ok = 1'b1;
      r.px = 17'(clamp_pos(round_q30(cur_radius, round_q30(sth, cp))));
      r.py = 17'(clamp_pos(round_q30(cur_radius, round_q30(sth, sp))));
      r.pz = 17'(clamp_pos(round_q30(cur_radius, ct)));
      r.u  = 17'(u);
      r.v  = 17'(v);
    end else begin
      if (st >= stacks || sl >= slices) return r;
      cap_top = (st == 0);
      cap_bot = (st == stacks - 1);
      if (sec && (cap_top || cap_bot)) return r;
      w   = slices + 1;
      top = st * w + sl;
      bot = top + w;
      r.ok = 1'b1;
      r.ca = 17'(top);
      if (sec) begin
        r.cb = 17'(bot + 1); r.cc = 17'(top + 1);
      end else if (cap_bot && !cap_top) begin
        r.cb = 17'(bot); r.cc = 17'(top + 1);
      end else begin
        r.cb = 17'(bot); r.cc = 17'(bot + 1);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    $display("%0t mismatch %s: got 0x%05h want 0x%05h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    beats_out  = 0;
    pending    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sphere_res_t e;
    if (!rst_ni) begin
      cur_stacks <= 8'd16;
      cur_slices <= 8'd16;
      cur_radius <= 16'd256;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (uvs_pkg::cfg_reg_e'(cfg_index_i))
          uvs_pkg::REG_STACKS: cur_stacks <= cfg_data_i[7:0];
          uvs_pkg::REG_SLICES: cur_slices <= cfg_data_i[7:0];
          uvs_pkg::REG_RADIUS: cur_radius <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        expected_q.insert(expected_q.size(),
                          predict_mesh(uvs_pkg::cmd_e'(command_i), stack_index_i,
                                       slice_index_i, second_triangle_i));
      if (out_valid_o && out_ready_i) begin
        beats_out++;
        if (expected_q.size() == 0) begin
          $display("%0t unexpected output beat", $realtime);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (valid_res_o !== e.ok) report_mismatch("valid_res", 17'(valid_res_o), 17'(e.ok));
          if (pos_x_o !== e.px) report_mismatch("pos_x", pos_x_o, e.px);
          if (pos_y_o !== e.py) report_mismatch("pos_y", pos_y_o, e.py);
          if (pos_z_o !== e.pz) report_mismatch("pos_z", pos_z_o, e.pz);
          if (tex_u_o !== e.u) report_mismatch("tex_u", tex_u_o, e.u);
          if (tex_v_o !== e.v) report_mismatch("tex_v", tex_v_o, e.v);
          if (corner_a_o !== e.ca) report_mismatch("corner_a", corner_a_o, e.ca);
          if (corner_b_o !== e.cb) report_mismatch("corner_b", corner_b_o, e.cb);
          if (corner_c_o !== e.cc) report_mismatch("corner_c", corner_c_o, e.cc);
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

[tb/sv/uv_sphere_vertex_triangle_gen_core_test.sv]
`timescale 1ns / 1ps

module uv_sphere_vertex_triangle_gen_core_test;

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = 1'b0;
  logic [7:0]  stack_index_i = '0;
  logic [7:0]  slice_index_i = '0;
  logic        second_triangle_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  logic signed [uvs_pkg::POS_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [uvs_pkg::UV_W-1:0]  tex_u_o, tex_v_o;
  logic [uvs_pkg::CRN_W-1:0] corner_a_o, corner_b_o, corner_c_o;

  int   fail_count, pending, beats_out;
  int   items_sent = 0;
  int   settings_used = 0;
  bit   quiet = 0;
  bit   hold_req = 0;
  int   stall_cnt = 0;
  logic [7:0] set_stacks = 8'd16, set_slices = 8'd16;

  uv_sphere_vertex_triangle_gen_core u_top (.*);

  uv_sphere_vertex_triangle_gen_core_checker u_chk (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_req(input uvs_pkg::cmd_e cmd, input logic [7:0] st,
                          input logic [7:0] sl, input logic sec);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    stack_index_i     <= st;
    slice_index_i     <= sl;
    second_triangle_i <= sec;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input uvs_pkg::cfg_reg_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_sphere(input logic [7:0] stacks, input logic [7:0] slices,
                            input logic [15:0] rad);
    wait_drained();
    write_reg(uvs_pkg::REG_STACKS, {8'($urandom), stacks});
    write_reg(uvs_pkg::REG_SLICES, {8'($urandom), slices});
    write_reg(uvs_pkg::REG_RADIUS, rad);
    set_stacks = stacks;
    set_slices = slices;
    settings_used++;
  endtask

  task automatic random_reqs(input int n);
    logic [7:0] st, sl;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) begin
        st = 8'($urandom_range(0, int'(set_stacks) + 1));
        sl = 8'($urandom_range(0, int'(set_slices) + 1));
      end else begin
        st = 8'($urandom);
        sl = 8'($urandom);
      end
      send_req(uvs_pkg::cmd_e'($urandom_range(1)), st, sl, 1'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: 16 x 16, radius 256
    send_req(uvs_pkg::CMD_VERTEX, 8'd0, 8'd0, 1'b0);
    send_req(uvs_pkg::CMD_VERTEX, 8'd16, 8'd16, 1'b1);
    send_req(uvs_pkg::CMD_VERTEX, 8'd8, 8'd4, 1'b0);
    send_req(uvs_pkg::CMD_VERTEX, 8'd17, 8'd0, 1'b0);
    send_req(uvs_pkg::CMD_VERTEX, 8'd0, 8'd17, 1'b0);
    send_req(uvs_pkg::CMD_VERTEX, 8'd255, 8'd255, 1'b1);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd0, 8'd0, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd0, 8'd3, 1'b1);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd15, 8'd15, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd15, 8'd2, 1'b1);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd7, 8'd5, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd7, 8'd5, 1'b1);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd16, 8'd0, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd0, 8'd16, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd255, 8'd255, 1'b1);

    wait_drained();
    write_reg(uvs_pkg::cfg_reg_e'(2'd3), 16'hFFFF);
    set_sphere(8'd2, 8'd1, 16'd0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd0, 8'd0, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd1, 8'd0, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd1, 8'd0, 1'b1);
    send_req(uvs_pkg::CMD_VERTEX, 8'd2, 8'd1, 1'b0);
    set_sphere(8'd255, 8'd255, 16'hFFFF);
    send_req(uvs_pkg::CMD_VERTEX, 8'd128, 8'd0, 1'b0);
    send_req(uvs_pkg::CMD_VERTEX, 8'd255, 8'd255, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd254, 8'd254, 1'b0);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd253, 8'd254, 1'b1);
    set_sphere(8'd1, 8'd5, 16'd300);
    send_req(uvs_pkg::CMD_VERTEX, 8'd0, 8'd0, 1'b0);
    set_sphere(8'd5, 8'd0, 16'd300);
    send_req(uvs_pkg::CMD_TRIANGLE, 8'd0, 8'd0, 1'b0);

    set_sphere(8'd16, 8'd16, 16'd256);
    quiet = 1;
    random_reqs(120);
    quiet = 0;
    hold_req = 1;
    random_reqs(150);

    set_sphere(8'd255, 8'd255, 16'hFFFF);
    random_reqs(150);
    set_sphere(8'd2, 8'd1, 16'd0);
    random_reqs(80);
    set_sphere(8'd3, 8'd7, 16'd1000);
    random_reqs(120);
    set_sphere(8'd255, 8'd1, 16'd40000);
    random_reqs(100);
    set_sphere(8'd2, 8'd255, 16'd512);
    random_reqs(100);
    set_sphere(8'd0, 8'd0, 16'd77);
    random_reqs(20);
    for (int k = 0; k < 4; k++) begin
      set_sphere(8'($urandom_range(2, 255)), 8'($urandom_range(1, 255)), 16'($urandom));
      random_reqs(100);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d sphere settings", items_sent,
             beats_out, settings_used);
    $display("vertices, triangles, caps, out-of-range and degenerate spheres, back-pressure");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
